### src/afr_pkg.sv
package afr_pkg;

    localparam int STATUS_W = 2;
    localparam int BYTE_W = 8;
    localparam int TIMEOUT_W = 16;
    localparam int INDEX_W = 6;

    // The buffer index wraps at this depth, as does byte_index.
    localparam int STORE_DEPTH = 64;
    localparam int DATA_DEPTH_DEFAULT = 64;

    // Count width that holds a data count up to one beyond the store depth.
    localparam int COUNT_W = 7;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] GOOD_SUM = 8'hFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd7000;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_TYPE   = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHECK  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RD_IDLE = 2'd0,
        RD_READ = 2'd1,
        RD_LOAD = 2'd2
    } rd_state_t;

endpackage

### src/api_frame_receiver.sv
// An error or status-only result is in the output register in the cycle after the
// transfer that causes it. Buffered data comes out one byte at a time (memory read,
// then output load), starting after the checksum transfer; each load waits on out_stall.
// Throughput: one input transfer per cycle; input stalls while buffered data bytes
// are read out, and while a held result waits on out_stall.
// Reset (rst_n, asynchronous, active low): hunting, timeout register 7000, buffer not reset.
module api_frame_receiver #(
    parameter int DATA_DEPTH = afr_pkg::DATA_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [afr_pkg::BYTE_W-1:0]       rx_byte,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [afr_pkg::STATUS_W-1:0]     status,
    output logic [afr_pkg::BYTE_W-1:0]       frame_type,
    output logic                             data_valid,
    output logic [afr_pkg::BYTE_W-1:0]       data_byte,
    output logic [afr_pkg::INDEX_W-1:0]      byte_index,
    output logic                             last,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [afr_pkg::TIMEOUT_W-1:0]    cfg_data
);

    import afr_pkg::*;

    // Frame parsing state.
    phase_t                 phase_reg, phase_next;
    logic [TIMEOUT_W-1:0]   frame_len_reg, frame_len_next;
    logic [COUNT_W-1:0]     data_count_reg, data_count_next;
    logic [COUNT_W-1:0]     bytes_seen_reg, bytes_seen_next;
    logic [BYTE_W-1:0]      type_byte_reg, type_byte_next;
    logic [BYTE_W-1:0]      running_sum_reg, running_sum_next;
    logic [TIMEOUT_W-1:0]   idle_count_reg, idle_count_next;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    // Readout sequencer.
    rd_state_t              rd_state_reg, rd_state_next;
    logic [COUNT_W-1:0]     rd_idx_reg, rd_idx_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [BYTE_W-1:0]      frame_type_reg, frame_type_next;
    logic                   data_valid_reg, data_valid_next;
    logic [BYTE_W-1:0]      data_byte_reg, data_byte_next;
    logic [INDEX_W-1:0]     byte_index_reg, byte_index_next;
    logic                   last_reg, last_next;
    logic                   res_load;

    // Data buffer.
    logic [BYTE_W-1:0]      store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]      mem_q_reg;
    logic                   mem_we;
    logic                   mem_re;

    logic                   accept;
    logic                   out_free;
    logic [TIMEOUT_W-1:0]   len_full;
    logic [TIMEOUT_W-1:0]   idle_inc;
    logic [COUNT_W-1:0]     seen_inc;
    logic [BYTE_W-1:0]      sum_add;

    // The output register is free when empty or when its result is taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    assign len_full = {frame_len_reg[TIMEOUT_W-1:BYTE_W], rx_byte};
    assign idle_inc = idle_count_reg + 16'd1;
    assign seen_inc = bytes_seen_reg + 7'd1;
    assign sum_add  = running_sum_reg + rx_byte;

    // Configuration is always ready; the user must write it only while idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Handshake and memory control.
    always_comb
    begin
        cfg_ready = 1'b1;
        // Inputs wait during readout and whenever a result could not be loaded.
        in_stall  = (rd_state_reg != RD_IDLE) || !out_free;
        mem_we    = accept && !func && (phase_reg == PH_DATA);
        mem_re    = (rd_state_reg == RD_READ);
    end

    // Next state of the parser, the readout sequencer and the output register.
    always_comb
    begin
        phase_next       = phase_reg;
        frame_len_next   = frame_len_reg;
        data_count_next  = data_count_reg;
        bytes_seen_next  = bytes_seen_reg;
        type_byte_next   = type_byte_reg;
        running_sum_next = running_sum_reg;
        idle_count_next  = idle_count_reg;
        rd_state_next    = rd_state_reg;
        rd_idx_next      = rd_idx_reg;

        res_load         = 1'b0;
        status_next      = status_reg;
        frame_type_next  = frame_type_reg;
        data_valid_next  = data_valid_reg;
        data_byte_next   = data_byte_reg;
        byte_index_next  = byte_index_reg;
        last_next        = last_reg;

        if (accept)
        begin
            if (func)
            begin
                // A tick counts idle time only inside a frame. The count wrapping to
                // zero is treated as a timeout as well.
                if (phase_reg inside {PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_DATA, PH_CHECK})
                begin
                    if ((idle_inc >= timeout_reg) || (idle_inc == '0))
                    begin
                        res_load        = 1'b1;
                        status_next     = ST_TIMEOUT;
                        frame_type_next = '0;
                        data_valid_next = 1'b0;
                        data_byte_next  = '0;
                        byte_index_next = '0;
                        last_next       = 1'b1;
                        phase_next      = PH_HUNT;
                        idle_count_next = '0;
                    end
                    else
                    begin
                        idle_count_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_count_next = '0;
                case (phase_reg)
                    PH_LEN_HI:
                    begin
                        frame_len_next = {rx_byte, {BYTE_W{1'b0}}};
                        phase_next     = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        frame_len_next = len_full;
                        // A zero length or more data than the buffer allows is refused.
                        if ((len_full == '0) ||
                            ((len_full - 16'd1) > TIMEOUT_W'(DATA_DEPTH)))
                        begin
                            res_load        = 1'b1;
                            status_next     = ST_LENGTH;
                            frame_type_next = '0;
                            data_valid_next = 1'b0;
                            data_byte_next  = '0;
                            byte_index_next = '0;
                            last_next       = 1'b1;
                            phase_next      = PH_HUNT;
                        end
                        else
                        begin
                            data_count_next = len_full[COUNT_W-1:0] - 7'd1;
                            phase_next      = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_byte_next   = rx_byte;
                        running_sum_next = rx_byte;
                        bytes_seen_next  = '0;
                        phase_next       = (data_count_reg == '0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        running_sum_next = sum_add;
                        bytes_seen_next  = seen_inc;
                        if (seen_inc >= data_count_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        running_sum_next = sum_add;
                        phase_next       = PH_HUNT;
                        if (sum_add != GOOD_SUM)
                        begin
                            res_load        = 1'b1;
                            status_next     = ST_CHECKSUM;
                            frame_type_next = type_byte_reg;
                            data_valid_next = 1'b0;
                            data_byte_next  = '0;
                            byte_index_next = '0;
                            last_next       = 1'b1;
                        end
                        else if (data_count_reg == '0)
                        begin
                            res_load        = 1'b1;
                            status_next     = ST_OK;
                            frame_type_next = type_byte_reg;
                            data_valid_next = 1'b0;
                            data_byte_next  = '0;
                            byte_index_next = '0;
                            last_next       = 1'b1;
                        end
                        else
                        begin
                            rd_state_next = RD_READ;
                            rd_idx_next   = '0;
                        end
                    end
                    default:
                    begin
                        // Hunting, and any unused phase code behaves as hunting.
                        phase_next = PH_HUNT;
                        if (rx_byte == START_BYTE)
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                endcase
            end
        end

        // Readout: read one buffer entry, then load it into the output register.
        case (rd_state_reg)
            RD_READ:
            begin
                rd_state_next = RD_LOAD;
            end
            RD_LOAD:
            begin
                if (out_free)
                begin
                    res_load        = 1'b1;
                    status_next     = ST_OK;
                    frame_type_next = type_byte_reg;
                    data_valid_next = 1'b1;
                    data_byte_next  = mem_q_reg;
                    byte_index_next = rd_idx_reg[INDEX_W-1:0];
                    last_next       = ((rd_idx_reg + 7'd1) == data_count_reg);
                    rd_idx_next     = rd_idx_reg + 7'd1;
                    rd_state_next   = last_next ? RD_IDLE : RD_READ;
                end
            end
            default:
            begin
            end
        endcase

        out_valid_next = res_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            frame_len_reg   <= '0;
            data_count_reg  <= '0;
            bytes_seen_reg  <= '0;
            type_byte_reg   <= '0;
            running_sum_reg <= '0;
            idle_count_reg  <= '0;
            rd_state_reg    <= RD_IDLE;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            frame_len_reg   <= frame_len_next;
            data_count_reg  <= data_count_next;
            bytes_seen_reg  <= bytes_seen_next;
            type_byte_reg   <= type_byte_next;
            running_sum_reg <= running_sum_next;
            idle_count_reg  <= idle_count_next;
            rd_state_reg    <= rd_state_next;
            rd_idx_reg      <= rd_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload holds while the result waits.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg     <= status_next;
            frame_type_reg <= frame_type_next;
            data_valid_reg <= data_valid_next;
            data_byte_reg  <= data_byte_next;
            byte_index_reg <= byte_index_next;
            last_reg       <= last_next;
        end
    end

    // Data buffer with a registered read port. The index wraps at the store depth.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[bytes_seen_reg[INDEX_W-1:0]] <= rx_byte;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[rd_idx_reg[INDEX_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign frame_type = frame_type_reg;
    assign data_valid = data_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign last       = last_reg;

endmodule
